// ===== sv/qvr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the quaternion vector rotation unit.
// No dependencies; every other file refers to it by scoped names.
package qvr_pkg;

    localparam int CompW     = 16;
    localparam int ProdW     = 2 * CompW;
    localparam int TW        = ProdW + 1;
    localparam int Prod2W    = CompW + TW;
    localparam int AccW      = Prod2W + 3;
    localparam int FracShift = 28;
    localparam int RndW      = AccW - FracShift;
    localparam int CfgIdxW   = 8;

    localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracShift - 1);
    localparam logic signed [RndW-1:0] SatHi =
        {{(RndW - CompW + 1){1'b0}}, {(CompW - 1){1'b1}}};
    localparam logic signed [RndW-1:0] SatLo =
        {{(RndW - CompW + 1){1'b1}}, {(CompW - 1){1'b0}}};

    localparam logic [CfgIdxW-1:0] CfgRotS = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgRotX = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgRotY = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgRotZ = CfgIdxW'(3);

    typedef logic signed [CompW-1:0]  comp_t;
    typedef logic signed [TW-1:0]     tsum_t;
    typedef logic signed [AccW-1:0]   acc_t;

    localparam comp_t RotSReset = comp_t'(16384);
    localparam comp_t RotVReset = comp_t'(0);

    typedef struct packed {
        comp_t s;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec3_t;

    typedef struct packed {
        tsum_t ts;
        tsum_t tx;
        tsum_t ty;
        tsum_t tz;
    } tvec_t;

    typedef struct packed {
        acc_t rx;
        acc_t ry;
        acc_t rz;
    } racc_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        logic  clipped;
    } res_t;

    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
    } stage_ctl_t;

endpackage

// ===== sv/qvr_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: vector requests, results, register writes.
// Depends on qvr_pkg.
interface qvr_vec_if;
    logic          valid;
    logic          ready;
    qvr_pkg::comp_t vec_x;
    qvr_pkg::comp_t vec_y;
    qvr_pkg::comp_t vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_res_if;
    logic           valid;
    logic           ready;
    qvr_pkg::comp_t out_x;
    qvr_pkg::comp_t out_y;
    qvr_pkg::comp_t out_z;
    logic           clipped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input clipped, output ready);
endinterface

interface qvr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [qvr_pkg::CfgIdxW-1:0]  index;
    logic [qvr_pkg::CompW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/qvr_cross.sv =====
`timescale 1ns / 1ps
// First half product t = (0, v) * conj(q): product stage, then sum stage.
// Depends on qvr_pkg.
module qvr_cross (
    input  logic                clk,
    input  qvr_pkg::stage_ctl_t ctl,
    input  qvr_pkg::quat_t      q,
    input  qvr_pkg::vec3_t      v,
    output qvr_pkg::tvec_t      t
);

    logic signed [qvr_pkg::ProdW-1:0] vxux_reg, vyuy_reg, vzuz_reg;
    logic signed [qvr_pkg::ProdW-1:0] svx_reg, vyuz_reg, vzuy_reg;
    logic signed [qvr_pkg::ProdW-1:0] svy_reg, vzux_reg, vxuz_reg;
    logic signed [qvr_pkg::ProdW-1:0] svz_reg, vxuy_reg, vyux_reg;
    qvr_pkg::tvec_t                   t_reg;
    qvr_pkg::tvec_t                   t_next;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            vxux_reg <= v.x * q.x;
            vyuy_reg <= v.y * q.y;
            vzuz_reg <= v.z * q.z;
            svx_reg  <= q.s * v.x;
            vyuz_reg <= v.y * q.z;
            vzuy_reg <= v.z * q.y;
            svy_reg  <= q.s * v.y;
            vzux_reg <= v.z * q.x;
            vxuz_reg <= v.x * q.z;
            svz_reg  <= q.s * v.z;
            vxuy_reg <= v.x * q.y;
            vyux_reg <= v.y * q.x;
        end
    end

    always_comb
    begin
        t_next.ts = qvr_pkg::TW'(vxux_reg) + qvr_pkg::TW'(vyuy_reg) + qvr_pkg::TW'(vzuz_reg);
        t_next.tx = qvr_pkg::TW'(svx_reg) - qvr_pkg::TW'(vyuz_reg) + qvr_pkg::TW'(vzuy_reg);
        t_next.ty = qvr_pkg::TW'(svy_reg) - qvr_pkg::TW'(vzux_reg) + qvr_pkg::TW'(vxuz_reg);
        t_next.tz = qvr_pkg::TW'(svz_reg) - qvr_pkg::TW'(vxuy_reg) + qvr_pkg::TW'(vyux_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule

// ===== sv/qvr_mix.sv =====
`timescale 1ns / 1ps
// Second half product: vector part of q * t, product stage, then sum stage
// with the rounding offset folded in. Depends on qvr_pkg.
module qvr_mix (
    input  logic                clk,
    input  qvr_pkg::stage_ctl_t ctl,
    input  qvr_pkg::quat_t      q,
    input  qvr_pkg::tvec_t      t,
    output qvr_pkg::racc_t      acc
);

    logic signed [qvr_pkg::Prod2W-1:0] stx_reg, tsux_reg, uytz_reg, uzty_reg;
    logic signed [qvr_pkg::Prod2W-1:0] sty_reg, tsuy_reg, uztx_reg, uxtz_reg;
    logic signed [qvr_pkg::Prod2W-1:0] stz_reg, tsuz_reg, uxty_reg, uytx_reg;
    qvr_pkg::racc_t                    acc_reg;
    qvr_pkg::racc_t                    acc_next;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            stx_reg  <= q.s * t.tx;
            tsux_reg <= t.ts * q.x;
            uytz_reg <= q.y * t.tz;
            uzty_reg <= q.z * t.ty;
            sty_reg  <= q.s * t.ty;
            tsuy_reg <= t.ts * q.y;
            uztx_reg <= q.z * t.tx;
            uxtz_reg <= q.x * t.tz;
            stz_reg  <= q.s * t.tz;
            tsuz_reg <= t.ts * q.z;
            uxty_reg <= q.x * t.ty;
            uytx_reg <= q.y * t.tx;
        end
    end

    always_comb
    begin
        acc_next.rx = qvr_pkg::AccW'(stx_reg) + qvr_pkg::AccW'(tsux_reg)
                    + qvr_pkg::AccW'(uytz_reg) - qvr_pkg::AccW'(uzty_reg) + qvr_pkg::RoundHalf;
        acc_next.ry = qvr_pkg::AccW'(sty_reg) + qvr_pkg::AccW'(tsuy_reg)
                    + qvr_pkg::AccW'(uztx_reg) - qvr_pkg::AccW'(uxtz_reg) + qvr_pkg::RoundHalf;
        acc_next.rz = qvr_pkg::AccW'(stz_reg) + qvr_pkg::AccW'(tsuz_reg)
                    + qvr_pkg::AccW'(uxty_reg) - qvr_pkg::AccW'(uytx_reg) + qvr_pkg::RoundHalf;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== sv/qvr_sat.sv =====
`timescale 1ns / 1ps
// Output stage: drop the fraction bits, saturate to 16 bits, flag clipping.
// Depends on qvr_pkg.
module qvr_sat (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ld,
    input  logic           res_valid,
    input  qvr_pkg::racc_t acc,
    output qvr_pkg::res_t  res
);

    logic signed [qvr_pkg::RndW-1:0] rnd_x, rnd_y, rnd_z;
    logic                            hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;
    qvr_pkg::res_t                   res_reg;
    qvr_pkg::res_t                   res_next;

    function automatic qvr_pkg::comp_t clamp(input logic signed [qvr_pkg::RndW-1:0] r,
                                             input logic hi, input logic lo);
        qvr_pkg::comp_t c;
        priority if (hi)
            c = qvr_pkg::SatHi[qvr_pkg::CompW-1:0];
        else if (lo)
            c = qvr_pkg::SatLo[qvr_pkg::CompW-1:0];
        else
            c = r[qvr_pkg::CompW-1:0];
        return c;
    endfunction

    always_comb
    begin
        rnd_x = qvr_pkg::RndW'(acc.rx >>> qvr_pkg::FracShift);
        rnd_y = qvr_pkg::RndW'(acc.ry >>> qvr_pkg::FracShift);
        rnd_z = qvr_pkg::RndW'(acc.rz >>> qvr_pkg::FracShift);
        hi_x  = rnd_x > qvr_pkg::SatHi;
        lo_x  = rnd_x < qvr_pkg::SatLo;
        hi_y  = rnd_y > qvr_pkg::SatHi;
        lo_y  = rnd_y < qvr_pkg::SatLo;
        hi_z  = rnd_z > qvr_pkg::SatHi;
        lo_z  = rnd_z < qvr_pkg::SatLo;
        res_next.out_x   = clamp(rnd_x, hi_x, lo_x);
        res_next.out_y   = clamp(rnd_y, hi_y, lo_y);
        res_next.out_z   = clamp(rnd_z, hi_z, lo_z);
        res_next.clipped = hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.clipped) |->
            (res_reg.out_x == qvr_pkg::SatHi[qvr_pkg::CompW-1:0] ||
             res_reg.out_x == qvr_pkg::SatLo[qvr_pkg::CompW-1:0] ||
             res_reg.out_y == qvr_pkg::SatHi[qvr_pkg::CompW-1:0] ||
             res_reg.out_y == qvr_pkg::SatLo[qvr_pkg::CompW-1:0] ||
             res_reg.out_z == qvr_pkg::SatHi[qvr_pkg::CompW-1:0] ||
             res_reg.out_z == qvr_pkg::SatLo[qvr_pkg::CompW-1:0]))
        else $error("clipped set with no component at a limit");

    a_in_range_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (ld && !res_next.clipped) |=> (res_reg.out_x == $past(rnd_x[qvr_pkg::CompW-1:0])))
        else $error("unclipped x component altered");

endmodule

// ===== sv/quaternion_vector_rotation_unit.sv =====
`timescale 1ns / 1ps
// Top level: rotation registers, five-stage valid pipeline, channel wiring.
// Depends on qvr_pkg, qvr_ifs, qvr_cross, qvr_mix, qvr_sat.
//
//   port  | dir | payload                        | taken when
//   ------+-----+--------------------------------+------------------------
//   vec   | in  | vec_x, vec_y, vec_z            | vec.valid && vec.ready
//   res   | out | out_x, out_y, out_z, clipped   | res.valid && res.ready
//   cfg   | in  | index (0 s, 1 x, 2 y, 3 z), data | cfg.valid && cfg.ready
//
// One request per cycle while no stalled result backs up the pipeline.
// Stages: vector products, t sums, second products, wide sums, round/saturate.
// Reset clears all stage valid bits and loads the identity rotation.
// A stalled result holds only the stages behind it that are full; bubbles close up.
// cfg.ready is always high; indexes beyond three are ignored.
module quaternion_vector_rotation_unit (
    input logic       clk,
    input logic       rst_n,
    qvr_vec_if.sink   vec,
    qvr_res_if.source res,
    qvr_cfg_if.sink   cfg
);

    localparam int NumStages = 5;

    qvr_pkg::quat_t       rot_reg;
    qvr_pkg::quat_t       rot_next;
    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages:0]   rdy;
    logic [NumStages-1:0] vin;
    logic [NumStages-1:0] ld;
    qvr_pkg::vec3_t       v_in;
    qvr_pkg::tvec_t       t_mid;
    qvr_pkg::racc_t       acc_mid;
    qvr_pkg::res_t        res_out;
    qvr_pkg::stage_ctl_t  cross_ctl;
    qvr_pkg::stage_ctl_t  mix_ctl;
    logic                 in_acc;
    logic                 out_acc;

    always_comb
    begin
        rot_next = rot_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                qvr_pkg::CfgRotS: rot_next.s = cfg.data;
                qvr_pkg::CfgRotX: rot_next.x = cfg.data;
                qvr_pkg::CfgRotY: rot_next.y = cfg.data;
                qvr_pkg::CfgRotZ: rot_next.z = cfg.data;
                default:          rot_next = rot_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg.s <= qvr_pkg::RotSReset;
            rot_reg.x <= qvr_pkg::RotVReset;
            rot_reg.y <= qvr_pkg::RotVReset;
            rot_reg.z <= qvr_pkg::RotVReset;
        end
        else
        begin
            rot_reg <= rot_next;
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        rdy[NumStages] = res.ready;
        for (int k = NumStages - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        vin[0] = vec.valid;
        for (int k = 1; k < NumStages; k++)
        begin
            vin[k] = valid_reg[k-1];
        end
        for (int k = 0; k < NumStages; k++)
        begin
            ld[k]         = vin[k] && rdy[k];
            valid_next[k] = rdy[k] ? vin[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign vec.ready = rdy[0];
    assign v_in      = '{x: vec.vec_x, y: vec.vec_y, z: vec.vec_z};
    assign cross_ctl = '{ld_prod: ld[0], ld_sum: ld[1]};
    assign mix_ctl   = '{ld_prod: ld[2], ld_sum: ld[3]};

    qvr_cross u_cross (
        .clk (clk),
        .ctl (cross_ctl),
        .q   (rot_reg),
        .v   (v_in),
        .t   (t_mid)
    );

    qvr_mix u_mix (
        .clk (clk),
        .ctl (mix_ctl),
        .q   (rot_reg),
        .t   (t_mid),
        .acc (acc_mid)
    );

    qvr_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld[NumStages-1]),
        .res_valid (valid_reg[NumStages-1]),
        .acc       (acc_mid),
        .res       (res_out)
    );

    assign res.valid   = valid_reg[NumStages-1];
    assign res.out_x   = res_out.out_x;
    assign res.out_y   = res_out.out_y;
    assign res.out_z   = res_out.out_z;
    assign res.clipped = res_out.clipped;

    assign in_acc  = vec.valid && vec.ready;
    assign out_acc = res.valid && res.ready;

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !res.ready) |-> !vec.ready)
        else $error("request taken with full, stalled pipeline");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> valid_reg[0])
        else $error("accepted request did not enter first stage");

    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ($countones(valid_reg) ==
                   $past($countones(valid_reg)) + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("request lost or duplicated in pipeline");

    a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid)
        else $error("stalled result dropped");

endmodule

// ===== sim/qvr_rotation_checker.sv =====
`timescale 1ns / 1ps
// Rotation checker: shadows the rotation registers, predicts the rotated vector
// for every accepted request and compares it with each accepted result.
// Depends on qvr_pkg and qvr_ifs.
module qvr_rotation_checker (
    input  logic clk,
    input  logic rst_n,
    qvr_vec_if   vec,
    qvr_res_if   res,
    qvr_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    qvr_pkg::quat_t rotation;
    qvr_pkg::res_t  rotated_queue[$];
    qvr_pkg::res_t  want;

    function automatic qvr_pkg::comp_t round_saturate(input longint wide, inout logic clip);
        longint rounded;
        rounded = (wide + (longint'(1) <<< (qvr_pkg::FracShift - 1))) >>> qvr_pkg::FracShift;
        if (rounded > 32767)
        begin
            clip = 1'b1;
            return qvr_pkg::comp_t'(32767);
        end
        if (rounded < -32768)
        begin
            clip = 1'b1;
            return qvr_pkg::comp_t'(-32768);
        end
        return qvr_pkg::comp_t'(rounded);
    endfunction

    function automatic qvr_pkg::res_t rotate_vector(input qvr_pkg::quat_t q,
                                                    input qvr_pkg::vec3_t v);
        longint qs, qx, qy, qz;
        longint px, py, pz;
        longint hs, hx, hy, hz;
        longint wx, wy, wz;
        logic   clip;
        qvr_pkg::res_t r;
        qs = longint'(q.s);
        qx = longint'(q.x);
        qy = longint'(q.y);
        qz = longint'(q.z);
        px = longint'(v.x);
        py = longint'(v.y);
        pz = longint'(v.z);
        // half product: (0, p) * conj(q)
        hs = px * qx + py * qy + pz * qz;
        hx = qs * px - (py * qz - pz * qy);
        hy = qs * py - (pz * qx - px * qz);
        hz = qs * pz - (px * qy - py * qx);
        // vector part of q * h
        wx = qs * hx + hs * qx + (qy * hz - qz * hy);
        wy = qs * hy + hs * qy + (qz * hx - qx * hz);
        wz = qs * hz + hs * qz + (qx * hy - qy * hx);
        clip = 1'b0;
        r.out_x = round_saturate(wx, clip);
        r.out_y = round_saturate(wy, clip);
        r.out_z = round_saturate(wz, clip);
        r.clipped = clip;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation = '{s: qvr_pkg::RotSReset, x: qvr_pkg::RotVReset,
                         y: qvr_pkg::RotVReset, z: qvr_pkg::RotVReset};
            rotated_queue.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    qvr_pkg::CfgRotS: rotation.s = qvr_pkg::comp_t'(cfg.data);
                    qvr_pkg::CfgRotX: rotation.x = qvr_pkg::comp_t'(cfg.data);
                    qvr_pkg::CfgRotY: rotation.y = qvr_pkg::comp_t'(cfg.data);
                    qvr_pkg::CfgRotZ: rotation.z = qvr_pkg::comp_t'(cfg.data);
                    default: ;
                endcase
            end
            if (vec.valid && vec.ready)
            begin
                rotated_queue.push_back(rotate_vector(rotation,
                    '{x: vec.vec_x, y: vec.vec_y, z: vec.vec_z}));
            end
            if (res.valid && res.ready)
            begin
                if (rotated_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = rotated_queue.pop_front();
                    if (res.out_x !== want.out_x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.out_x, res.out_x);
                        fail_count++;
                    end
                    if (res.out_y !== want.out_y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.out_y, res.out_y);
                        fail_count++;
                    end
                    if (res.out_z !== want.out_z)
                    begin
                        $error("out_z: expected %0d, got %0d", want.out_z, res.out_z);
                        fail_count++;
                    end
                    if (res.clipped !== want.clipped)
                    begin
                        $error("clipped: expected %0b, got %0b", want.clipped, res.clipped);
                        fail_count++;
                    end
                end
            end
            pending = rotated_queue.size();
        end
    end

endmodule

// ===== sim/quaternion_vector_rotation_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives rotation writes and vector requests into the block
// with random stalls; qvr_rotation_checker predicts and compares results.
// Depends on qvr_pkg, qvr_ifs, qvr_rotation_checker and the block itself.
module quaternion_vector_rotation_unit_test;

    localparam int CycleLimit = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   tx_idle = 1'b0;
    bit   rx_idle = 1'b0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;

    qvr_vec_if vec_ch ();
    qvr_res_if res_ch ();
    qvr_cfg_if cfg_ch ();

    quaternion_vector_rotation_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    qvr_rotation_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec        (vec_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("quaternion_vector_rotation_unit test failed");
            $finish;
        end
    end

    // result side: stall in bursts while rx_idle is set
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_idle && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    function automatic qvr_pkg::vec3_t make_vec(input int x, input int y, input int z);
        return '{x: qvr_pkg::comp_t'(x), y: qvr_pkg::comp_t'(y), z: qvr_pkg::comp_t'(z)};
    endfunction

    function automatic qvr_pkg::quat_t make_quat(input int s, input int x, input int y,
                                                 input int z);
        return '{s: qvr_pkg::comp_t'(s), x: qvr_pkg::comp_t'(x),
                 y: qvr_pkg::comp_t'(y), z: qvr_pkg::comp_t'(z)};
    endfunction

    function automatic qvr_pkg::comp_t spread_comp(input int span);
        return qvr_pkg::comp_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic qvr_pkg::comp_t pick_comp();
        case ($urandom_range(0, 6))
            0: return qvr_pkg::comp_t'(-32768);
            1: return qvr_pkg::comp_t'(-16384);
            2: return qvr_pkg::comp_t'(-1);
            3: return qvr_pkg::comp_t'(0);
            4: return qvr_pkg::comp_t'(1);
            5: return qvr_pkg::comp_t'(16384);
            default: return qvr_pkg::comp_t'(32767);
        endcase
    endfunction

    function automatic qvr_pkg::comp_t random_comp(input int mode);
        case (mode)
            0: return qvr_pkg::comp_t'($urandom);
            1: return spread_comp(64);
            2: return spread_comp(4096);
            3: return spread_comp(9000);
            4: return spread_comp(200);
            default: return pick_comp();
        endcase
    endfunction

    function automatic qvr_pkg::vec3_t random_vector();
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 3)
            mode = 5;
        return '{x: random_comp(mode), y: random_comp(mode), z: random_comp(mode)};
    endfunction

    function automatic qvr_pkg::quat_t random_quat();
        int mode;
        mode = $urandom_range(0, 4);
        if (mode == 1 || mode == 2)
            mode = 3;
        else if (mode == 3)
            mode = 5;
        return '{s: random_comp(mode), x: random_comp(mode),
                 y: random_comp(mode), z: random_comp(mode)};
    endfunction

    task automatic push_vector(input qvr_pkg::vec3_t v);
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= v.x;
        vec_ch.vec_y <= v.y;
        vec_ch.vec_z <= v.z;
        @(posedge clk);
        while (!vec_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [qvr_pkg::CfgIdxW-1:0] index,
                                  input logic [qvr_pkg::CompW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_rotation(input qvr_pkg::quat_t q);
        write_register(qvr_pkg::CfgRotS, q.s);
        write_register(qvr_pkg::CfgRotX, q.x);
        write_register(qvr_pkg::CfgRotY, q.y);
        write_register(qvr_pkg::CfgRotZ, q.z);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_ignored(input logic [qvr_pkg::CfgIdxW-1:0] index,
                                 input logic [qvr_pkg::CompW-1:0] data);
        write_register(index, data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        vec_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_burst(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (tx_idle && $urandom_range(0, 5) == 0)
            begin
                vec_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            push_vector(random_vector());
        end
    endtask

    initial
    begin
        vec_ch.valid <= 1'b0;
        vec_ch.vec_x <= '0;
        vec_ch.vec_y <= '0;
        vec_ch.vec_z <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // identity rotation out of reset
        push_vector(make_vec(32767, -32768, 0));
        push_vector(make_vec(-32768, 32767, -1));
        push_vector(make_vec(0, 0, 0));
        push_vector(make_vec(1, -1, 12345));
        drain();

        // half scale: several results land on a rounding tie
        write_rotation(make_quat(8192, 0, 0, 0));
        push_vector(make_vec(2, -2, 6));
        push_vector(make_vec(-6, 1, -1));
        push_vector(make_vec(3, -3, 32767));
        drain();

        // quarter turn about z
        write_rotation(make_quat(11585, 0, 0, 11585));
        push_vector(make_vec(1000, 0, 0));
        push_vector(make_vec(0, 1000, -500));
        push_vector(make_vec(32767, 32767, 0));
        drain();

        // far from unit norm: saturation both ways
        write_rotation(make_quat(-32768, -32768, -32768, -32768));
        push_vector(make_vec(32767, 32767, 32767));
        push_vector(make_vec(-32768, -32768, -32768));
        push_vector(make_vec(1, 0, 0));
        push_vector(make_vec(0, 0, 0));
        drain();
        write_rotation(make_quat(32767, 32767, 32767, 32767));
        push_vector(make_vec(-32768, 32767, -32768));
        push_vector(make_vec(100, -100, 50));
        drain();
        write_rotation(make_quat(0, 0, 0, 0));
        push_vector(make_vec(32767, -32768, 1234));
        drain();

        // half turn about x, then writes to unused indexes must not disturb it
        write_rotation(make_quat(0, 16384, 0, 0));
        push_vector(make_vec(10, 20, 30));
        drain();
        write_ignored(8'd4, 16'hFFFF);
        write_ignored(8'hFF, 16'h5A5A);
        push_vector(make_vec(10, 20, 30));
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            drain();
            tx_idle = (phase < 9) && ($urandom_range(0, 3) != 0);
            rx_idle = (phase < 9) && ($urandom_range(0, 3) != 0);
            write_rotation(random_quat());
            if ($urandom_range(0, 2) == 0)
                write_ignored(qvr_pkg::CfgIdxW'($urandom_range(4, 255)),
                              qvr_pkg::CompW'($urandom));
            if (phase == 4)
            begin
                send_burst(60);
                drain();
                send_burst(80);
            end
            else
            begin
                send_burst(140);
            end
        end
        drain();
        repeat (20) @(negedge clk);

        if (fail_count == 0)
            $display("quaternion_vector_rotation_unit test passed");
        else
            $display("quaternion_vector_rotation_unit test failed");
        $finish;
    end

endmodule
